// ===== rtl/cia_pkg.sv =====
// shared types, constants and status codes for the checked integer alu
package cia_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned KindWidth = 3;
   localparam int unsigned StatusWidth = 3;
   localparam int unsigned DivStages = DataWidth;

   typedef enum logic [KindWidth-1:0] {
      KIND_ADD = 3'd0,
      KIND_SUB = 3'd1,
      KIND_MUL = 3'd2,
      KIND_DIV = 3'd3,
      KIND_SHR = 3'd4,
      KIND_SHL = 3'd5
   } kind_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK       = 3'd0,
      ST_OVER     = 3'd1,
      ST_UNDER    = 3'd2,
      ST_DIVZERO  = 3'd3,
      ST_INEXACT  = 3'd4,
      ST_BADSHIFT = 3'd5,
      ST_NEGSHIFT = 3'd6
   } status_type;

   typedef struct packed {
      logic [KindWidth-1:0] kind;
      logic signed [DataWidth-1:0] operand_a;
      logic signed [DataWidth-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] result;
      logic [StatusWidth-1:0] status;
   } rsp_type;

   // item travelling along the chain of cells
   typedef struct packed {
      logic valid;
      logic [KindWidth-1:0] kind;
      logic signed [DataWidth-1:0] operand_a;
      logic signed [DataWidth-1:0] operand_b;
      logic [DataWidth-1:0] rem;
      logic [DataWidth-1:0] quo;
      logic [DataWidth-1:0] dvd;
      logic [DataWidth-1:0] dvs;
      logic signed [DataWidth-1:0] result;
      logic [StatusWidth-1:0] status;
   } slot_type;

endpackage

// ===== rtl/checked_integer_alu_top.sv =====
// checked integer alu: front stage, chain of divider cells, back stage
// start to rsp_valid: front register, each cell register, back register
// throughput: one transaction per cycle, busy is always low
// the divider chain holds one quotient bit per cell and sets the latency
// reset clears all valid flags; no responses follow reset until new starts
// the receiver cannot stall: each response is shown for exactly one cycle
module checked_integer_alu_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cia_pkg::req_type req_data,
   output logic             rsp_valid,
   output cia_pkg::rsp_type rsp_data
);

   localparam int unsigned DivStages = cia_pkg::DivStages;

   cia_pkg::slot_type chain [DivStages+1];
   logic [63:0] pp_ll, pp_mid;
   logic [63:0] prod_ff [DivStages];
   logic [63:0] prod_sum;

   assign busy = 1'b0;

   cia_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_req    (req_data),
      .out_slot  (chain[0]),
      .out_pp_ll (pp_ll),
      .out_pp_mid(pp_mid)
   );

   assign prod_sum = pp_ll + ({32'd0, pp_mid[63:32]} << 16) +
                     ({32'd0, pp_mid[31:0]} << 16);

   always_ff @(posedge clock) begin
      prod_ff[0] <= prod_sum;
      for (int i = 1; i < int'(DivStages); i++) begin
         prod_ff[i] <= prod_ff[i-1];
      end
   end

   for (genvar g = 0; g < int'(DivStages); g++) begin : g_cell
      cia_cell #(
         .BitIndex(DivStages - 1 - g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .in_slot (chain[g]),
         .out_slot(chain[g+1])
      );
   end

   cia_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_slot    (chain[DivStages]),
      .in_prod_mag(prod_ff[DivStages-1]),
      .out_valid  (rsp_valid),
      .out_rsp    (rsp_data)
   );

endmodule

// ===== rtl/cia_front.sv =====
// first stage: add, sub, shifts, partial products and divider setup
module cia_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  cia_pkg::req_type in_req,
   output cia_pkg::slot_type out_slot,
   output logic [63:0]      out_pp_ll,
   output logic [63:0]      out_pp_mid
);

   localparam int unsigned W = cia_pkg::DataWidth;

   cia_pkg::slot_type slot_in, slot_ff;
   logic [63:0] pp_ll_in, pp_ll_ff, pp_mid_in, pp_mid_ff;
   logic signed [W:0] sum_v;
   logic signed [W:0] dif_v;
   logic signed [2*W-1:0] shl_v;
   logic [W-1:0] mag_a, mag_b;
   logic [15:0] al, ah, bl, bh;

   always_comb begin
      slot_in = '0;
      slot_in.valid = in_valid;
      slot_in.kind = in_req.kind;
      slot_in.operand_a = in_req.operand_a;
      slot_in.operand_b = in_req.operand_b;
      slot_in.status = cia_pkg::ST_OK;
      sum_v = {in_req.operand_a[W-1], in_req.operand_a} +
              {in_req.operand_b[W-1], in_req.operand_b};
      dif_v = {in_req.operand_a[W-1], in_req.operand_a} -
              {in_req.operand_b[W-1], in_req.operand_b};
      shl_v = (2*W)'(in_req.operand_a) <<< in_req.operand_b[4:0];
      mag_a = in_req.operand_a[W-1] ? W'(-in_req.operand_a) : in_req.operand_a;
      mag_b = in_req.operand_b[W-1] ? W'(-in_req.operand_b) : in_req.operand_b;
      al = mag_a[15:0];
      ah = mag_a[31:16];
      bl = mag_b[15:0];
      bh = mag_b[31:16];
      pp_ll_in = {32'(ah * bh), 32'(al * bl)};
      pp_mid_in = {32'(ah * bl), 32'(al * bh)};
      slot_in.dvd = mag_a;
      slot_in.dvs = mag_b;
      case (in_req.kind)
         cia_pkg::KIND_ADD: begin
            if (sum_v[W] != sum_v[W-1]) begin
               slot_in.status = sum_v[W] ? cia_pkg::ST_UNDER : cia_pkg::ST_OVER;
            end else begin
               slot_in.result = sum_v[W-1:0];
            end
         end
         cia_pkg::KIND_SUB: begin
            if (dif_v[W] != dif_v[W-1]) begin
               slot_in.status = dif_v[W] ? cia_pkg::ST_UNDER : cia_pkg::ST_OVER;
            end else begin
               slot_in.result = dif_v[W-1:0];
            end
         end
         cia_pkg::KIND_SHR: begin
            if (in_req.operand_b[W-1:5] != '0) begin
               slot_in.status = cia_pkg::ST_BADSHIFT;
            end else if (in_req.operand_a[W-1]) begin
               slot_in.status = cia_pkg::ST_NEGSHIFT;
            end else begin
               slot_in.result = in_req.operand_a >> in_req.operand_b[4:0];
            end
         end
         cia_pkg::KIND_SHL: begin
            if (in_req.operand_b[W-1:5] != '0) begin
               slot_in.status = cia_pkg::ST_BADSHIFT;
            end else if (shl_v[2*W-1:W-1] != {(W+1){shl_v[2*W-1]}}) begin
               slot_in.status = shl_v[2*W-1] ? cia_pkg::ST_UNDER : cia_pkg::ST_OVER;
            end else begin
               slot_in.result = shl_v[W-1:0];
            end
         end
         cia_pkg::KIND_DIV: begin
            if (in_req.operand_b == '0) begin
               slot_in.status = cia_pkg::ST_DIVZERO;
            end else if (in_req.operand_a == {1'b1, {(W-1){1'b0}}} &&
                         in_req.operand_b == '1) begin
               slot_in.status = cia_pkg::ST_OVER;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
      end
      slot_ff.kind <= slot_in.kind;
      slot_ff.operand_a <= slot_in.operand_a;
      slot_ff.operand_b <= slot_in.operand_b;
      slot_ff.rem <= slot_in.rem;
      slot_ff.quo <= slot_in.quo;
      slot_ff.dvd <= slot_in.dvd;
      slot_ff.dvs <= slot_in.dvs;
      slot_ff.result <= slot_in.result;
      slot_ff.status <= slot_in.status;
      pp_ll_ff <= pp_ll_in;
      pp_mid_ff <= pp_mid_in;
   end

   assign out_slot = slot_ff;
   assign out_pp_ll = pp_ll_ff;
   assign out_pp_mid = pp_mid_ff;

endmodule

// ===== rtl/cia_cell.sv =====
// one divider cell: one restoring quotient bit per cycle, hands item to next cell
module cia_cell #(
   parameter int unsigned BitIndex = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  cia_pkg::slot_type in_slot,
   output cia_pkg::slot_type out_slot
);

   localparam int unsigned W = cia_pkg::DataWidth;

   cia_pkg::slot_type slot_in, slot_ff;
   logic [W:0] trial;
   logic [W-1:0] shifted;

   always_comb begin
      slot_in = in_slot;
      shifted = {in_slot.rem[W-2:0], in_slot.dvd[BitIndex]};
      trial = {1'b0, shifted} - {1'b0, in_slot.dvs};
      if (!trial[W]) begin
         slot_in.rem = trial[W-1:0];
         slot_in.quo[BitIndex] = 1'b1;
      end else begin
         slot_in.rem = shifted;
         slot_in.quo[BitIndex] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
      end
      slot_ff.kind <= slot_in.kind;
      slot_ff.operand_a <= slot_in.operand_a;
      slot_ff.operand_b <= slot_in.operand_b;
      slot_ff.rem <= slot_in.rem;
      slot_ff.quo <= slot_in.quo;
      slot_ff.dvd <= slot_in.dvd;
      slot_ff.dvs <= slot_in.dvs;
      slot_ff.result <= slot_in.result;
      slot_ff.status <= slot_in.status;
   end

   assign out_slot = slot_ff;

endmodule

// ===== rtl/cia_back.sv =====
// last stage: multiply range check, divide exactness check and sign fix, and response register
module cia_back (
   input  logic              clock,
   input  logic              reset,
   input  cia_pkg::slot_type in_slot,
   input  logic [63:0]       in_prod_mag,
   output logic              out_valid,
   output cia_pkg::rsp_type  out_rsp
);

   localparam int unsigned W = cia_pkg::DataWidth;

   cia_pkg::rsp_type rsp_in, rsp_ff;
   logic valid_ff;
   logic neg;
   logic [2*W:0] prod;

   always_comb begin
      rsp_in.result = in_slot.result;
      rsp_in.status = in_slot.status;
      neg = in_slot.operand_a[W-1] ^ in_slot.operand_b[W-1];
      prod = neg ? (2*W+1)'(-{1'b0, in_prod_mag}) : {1'b0, in_prod_mag};
      case (in_slot.kind)
         cia_pkg::KIND_MUL: begin
            if (prod[2*W:W-1] != {(W+2){prod[2*W]}}) begin
               rsp_in.status = prod[2*W] ? cia_pkg::ST_UNDER : cia_pkg::ST_OVER;
            end else begin
               rsp_in.result = prod[W-1:0];
            end
         end
         cia_pkg::KIND_DIV: begin
            if (in_slot.status == cia_pkg::ST_OK) begin
               if (in_slot.rem != '0) begin
                  rsp_in.status = cia_pkg::ST_INEXACT;
               end else begin
                  rsp_in.result = neg ? W'(-in_slot.quo) : in_slot.quo;
               end
            end
         end
         default: begin
         end
      endcase
      if (rsp_in.status != cia_pkg::ST_OK) begin
         rsp_in.result = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_slot.valid;
      end
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_rsp = rsp_ff;

endmodule
